// ===== src/dcc_cp_pkg.sv =====
// dcc command panel: shared types, codes and constants
// used by dcc_cp_frame, dcc_cp_ctrl and dcc_command_panel_unit; no dependencies
`timescale 1ns / 1ps

package dcc_cp_pkg;

    localparam int unsigned FRAME_W = 51;

    // button bit positions within one sample
    localparam int unsigned BTN_SEND  = 0;
    localparam int unsigned BTN_UP    = 1;
    localparam int unsigned BTN_LEFT  = 2;
    localparam int unsigned BTN_RIGHT = 3;
    localparam int unsigned BTN_DOWN  = 4;

    localparam logic [2:0] MAX_ADDRESS  = 3'd6;
    localparam logic [4:0] MAX_SPEED    = 5'd31;
    localparam logic [4:0] MAX_FUNCTION = 5'd22;

    // function selection ranges
    localparam logic [4:0] SEL_SPEED    = 5'd0;
    localparam logic [4:0] SEL_F0       = 5'd1;
    localparam logic [4:0] SEL_F1       = 5'd2;
    localparam logic [4:0] SEL_F4       = 5'd5;
    localparam logic [4:0] SEL_F5       = 5'd6;
    localparam logic [4:0] SEL_F8       = 5'd9;
    localparam logic [4:0] SEL_F9       = 5'd10;
    localparam logic [4:0] SEL_F12      = 5'd13;
    localparam logic [4:0] SEL_F13      = 5'd14;
    localparam logic [4:0] SEL_F20      = 5'd21;

    localparam logic [FRAME_W-1:0] PREAMBLE3 = 51'h7FFFFF0000000;
    localparam logic [FRAME_W-1:0] PREAMBLE4 = 51'h7FFE000000000;

    localparam logic [7:0] CMD_SPEED   = 8'h40;
    localparam logic [7:0] CMD_FG1     = 8'h80;
    localparam logic [7:0] CMD_FG2A    = 8'hB0;
    localparam logic [7:0] CMD_FG2B    = 8'hA0;
    localparam logic [7:0] CMD_F0_BIT  = 8'h10;
    localparam logic [7:0] CMD_FEXP    = 8'hDE;

    typedef enum logic [1:0] {
        FLD_FUNCTION  = 2'd0,
        FLD_ADDRESS   = 2'd1,
        FLD_DIRECTION = 2'd2,
        FLD_SPEED     = 2'd3
    } t_field;

    typedef struct packed {
        logic [4:0] function_select;
        logic [2:0] loco_address;
        logic       direction_bit;
        logic [4:0] speed_or_on;
        t_field     field_cursor;
    } t_panel_state;

    typedef struct packed {
        logic               send_valid;
        logic [FRAME_W-1:0] frame;
        logic [15:0]        led_word;
        logic [7:0]         segment_word;
    } t_result;

endpackage

// ===== src/dcc_cp_frame.sv =====
// dcc frame builder: speed, F0-F12 and F13-F20 packets with check byte; selections past F20
// give back the last frame unchanged; depends on dcc_cp_pkg
`timescale 1ns / 1ps

module dcc_cp_frame import dcc_cp_pkg::*; (
    input  t_panel_state        i_state,
    input  logic [FRAME_W-1:0]  i_last_frame,
    output logic [FRAME_W-1:0]  o_frame
);

    logic [4:0] sel;
    logic [2:0] addr;
    logic       on;
    logic [7:0] cmd;
    logic [7:0] data;
    logic [7:0] chk3;
    logic [7:0] chk4;

    always_comb begin
        sel  = i_state.function_select;
        addr = i_state.loco_address;
        on   = (i_state.speed_or_on == 5'd1);
        cmd  = CMD_SPEED | {2'b00, i_state.direction_bit, i_state.speed_or_on};
        data = 8'd0;
        if (sel == SEL_SPEED) begin
            cmd = CMD_SPEED | {2'b00, i_state.direction_bit, i_state.speed_or_on};
        end else if (sel == SEL_F0) begin
            cmd = CMD_FG1 | (on ? CMD_F0_BIT : 8'd0);
        end else if (sel <= SEL_F4) begin
            cmd = CMD_FG1 | (on ? (8'd1 << 3'(sel - SEL_F1)) : 8'd0);
        end else if (sel <= SEL_F8) begin
            cmd = CMD_FG2A | (on ? (8'd1 << 3'(sel - SEL_F5)) : 8'd0);
        end else if (sel <= SEL_F12) begin
            cmd = CMD_FG2B | (on ? (8'd1 << 3'(sel - SEL_F9)) : 8'd0);
        end
        // F20 lands on bit 7, i.e. 0x80
        if (on && sel >= SEL_F13 && sel <= SEL_F20) begin
            data = 8'd1 << 3'(sel - SEL_F13);
        end
        chk3 = {5'd0, addr} ^ cmd;
        chk4 = {5'd0, addr} ^ data ^ CMD_FEXP;

        if (sel <= SEL_F12) begin
            o_frame = PREAMBLE3 | (FRAME_W'(addr) << 19) | (FRAME_W'(cmd) << 10)
                    | (FRAME_W'(chk3) << 1) | FRAME_W'(1);
        end else if (sel <= SEL_F20) begin
            o_frame = PREAMBLE4 | (FRAME_W'(addr) << 28) | (FRAME_W'(CMD_FEXP) << 19)
                    | (FRAME_W'(data) << 10) | (FRAME_W'(chk4) << 1) | FRAME_W'(1);
        end else begin
            o_frame = i_last_frame;
        end
    end

endmodule

// ===== src/dcc_cp_ctrl.sv =====
// panel state: edge detection, cursor and field updates, frame memory, display words
// depends on dcc_cp_pkg and dcc_cp_frame
`timescale 1ns / 1ps

module dcc_cp_ctrl import dcc_cp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [4:0]  i_buttons,
    output t_result     o_result
);

    logic [4:0]          r_prev_buttons;
    t_panel_state        r_state;
    t_panel_state        n_state;
    logic [FRAME_W-1:0]  r_last_frame;
    logic [FRAME_W-1:0]  built_frame;
    logic [4:0]          edges;
    logic [4:0]          val;
    logic                speed_mode;

    dcc_cp_frame u_frame (
        .i_state      (r_state),
        .i_last_frame (r_last_frame),
        .o_frame      (built_frame)
    );

    always_comb begin
        edges   = i_buttons & ~r_prev_buttons;
        n_state = r_state;

        if (edges[BTN_UP]) begin
            unique case (n_state.field_cursor)
                FLD_FUNCTION: begin
                    if (n_state.function_select < MAX_FUNCTION) begin
                        n_state.function_select = n_state.function_select + 5'd1;
                        n_state.direction_bit   = 1'b0;
                        n_state.speed_or_on     = 5'd0;
                    end
                end
                FLD_ADDRESS: begin
                    if (n_state.loco_address < MAX_ADDRESS)
                        n_state.loco_address = n_state.loco_address + 3'd1;
                end
                FLD_DIRECTION: n_state.direction_bit = 1'b1;
                FLD_SPEED: begin
                    if (n_state.function_select == SEL_SPEED) begin
                        if (n_state.speed_or_on < MAX_SPEED)
                            n_state.speed_or_on = n_state.speed_or_on + 5'd1;
                    end else if (n_state.speed_or_on == 5'd0) begin
                        n_state.speed_or_on = 5'd1;
                    end
                end
            endcase
        end

        if (edges[BTN_LEFT]) begin
            unique case (n_state.field_cursor)
                FLD_SPEED: n_state.field_cursor =
                    (n_state.function_select == SEL_SPEED) ? FLD_DIRECTION : FLD_ADDRESS;
                FLD_DIRECTION: n_state.field_cursor = FLD_ADDRESS;
                FLD_ADDRESS:   n_state.field_cursor = FLD_FUNCTION;
                FLD_FUNCTION:  n_state.field_cursor = FLD_FUNCTION;
            endcase
        end

        if (edges[BTN_RIGHT]) begin
            unique case (n_state.field_cursor)
                FLD_FUNCTION:  n_state.field_cursor = FLD_ADDRESS;
                FLD_ADDRESS:   n_state.field_cursor =
                    (n_state.function_select == SEL_SPEED) ? FLD_DIRECTION : FLD_SPEED;
                FLD_DIRECTION: n_state.field_cursor = FLD_SPEED;
                FLD_SPEED:     n_state.field_cursor = FLD_SPEED;
            endcase
        end

        if (edges[BTN_DOWN]) begin
            unique case (n_state.field_cursor)
                FLD_FUNCTION: begin
                    if (n_state.function_select != 5'd0) begin
                        n_state.function_select = n_state.function_select - 5'd1;
                        n_state.direction_bit   = 1'b0;
                        n_state.speed_or_on     = 5'd0;
                    end
                end
                FLD_ADDRESS: begin
                    if (n_state.loco_address != 3'd0)
                        n_state.loco_address = n_state.loco_address - 3'd1;
                end
                FLD_DIRECTION: n_state.direction_bit = 1'b0;
                FLD_SPEED: begin
                    if (n_state.function_select == SEL_SPEED) begin
                        if (n_state.speed_or_on != 5'd0)
                            n_state.speed_or_on = n_state.speed_or_on - 5'd1;
                    end else if (n_state.speed_or_on == 5'd1) begin
                        n_state.speed_or_on = 5'd0;
                    end
                end
            endcase
        end

        unique case (n_state.field_cursor)
            FLD_FUNCTION:  val = n_state.function_select;
            FLD_ADDRESS:   val = {2'b00, n_state.loco_address};
            FLD_DIRECTION: val = {4'd0, n_state.direction_bit};
            FLD_SPEED:     val = n_state.speed_or_on;
        endcase
        speed_mode = (n_state.function_select == SEL_SPEED);

        o_result.send_valid   = edges[BTN_SEND];
        o_result.frame        = edges[BTN_SEND] ? built_frame : '0;
        // bits 6 and 0 are unused
        o_result.led_word     = {n_state.function_select, n_state.loco_address,
                                 n_state.direction_bit, 1'b0, n_state.speed_or_on, 1'b0};
        o_result.segment_word = {val, n_state.field_cursor, speed_mode};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_buttons <= 5'd0;
            r_state        <= '{function_select: 5'd0, loco_address: 3'd1,
                                direction_bit: 1'b0, speed_or_on: 5'd0,
                                field_cursor: FLD_FUNCTION};
            r_last_frame   <= '0;
        end else if (i_step) begin
            r_prev_buttons <= i_buttons;
            r_state        <= n_state;
            if (edges[BTN_SEND])
                r_last_frame <= built_frame;
        end
    end

    a_addr_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.loco_address <= MAX_ADDRESS)
        else $error("address beyond limit");

    a_func_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.function_select <= MAX_FUNCTION)
        else $error("function selection beyond limit");

    a_on_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.function_select != SEL_SPEED) |->
            (r_state.speed_or_on <= 5'd1 && !r_state.direction_bit))
        else $error("function mode with speed or direction set");

    a_dir_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.field_cursor == FLD_DIRECTION) |-> (r_state.function_select == SEL_SPEED))
        else $error("cursor on direction while a function is selected");

endmodule

// ===== src/dcc_command_panel_unit.sv =====
// top level of the dcc command panel: input register, panel logic, result register
// depends on dcc_cp_pkg and dcc_cp_ctrl
`timescale 1ns / 1ps

// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+-----------------------------------------
// buttons   | in        | i_valid / o_stall    | i_buttons
// result    | out       | o_valid / i_stall    | o_send_valid, o_frame, o_led_word,
//           |           |                      | o_segment_word
//
// one transaction per cycle sustained while the result side does not stall; a result is
// offered once its button transaction has passed the input register, then the result register
// the panel state and last frame are updated in the same edge that loads the result register
// synchronous active-low reset: address 1, speed mode, cursor on function, last frame zero
// a stall on the result side holds the result register; the input register then fills
// and o_stall rises, so no transaction is lost while the output waits

module dcc_command_panel_unit import dcc_cp_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [4:0]          i_buttons,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_send_valid,
    output logic [FRAME_W-1:0]  o_frame,
    output logic [15:0]         o_led_word,
    output logic [7:0]          o_segment_word
);

    logic        r_in_valid;
    logic [4:0]  r_in_buttons;
    logic        r_out_valid;
    t_result     r_out;
    t_result     step_result;
    logic        out_free;
    logic        step;
    logic        in_take;

    // result register can take a new value when empty or being drained
    assign out_free = !r_out_valid || !i_stall;
    assign step     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    dcc_cp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_buttons (r_in_buttons),
        .o_result  (step_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take)
            r_in_buttons <= i_buttons;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step)
            r_out <= step_result;
    end

    assign o_valid        = r_out_valid;
    assign o_send_valid   = r_out.send_valid;
    assign o_frame        = r_out.frame;
    assign o_led_word     = r_out.led_word;
    assign o_segment_word = r_out.segment_word;

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for dcc_command_panel_unit: button samples in, panel results out
// depends on dcc_cp_pkg and the block's rtl; carries its own model of the panel
`timescale 1ns / 1ps

module testbench;
    import dcc_cp_pkg::*;

    // one-hot button masks
    localparam logic [4:0] PRESS_SEND  = 5'd1 << BTN_SEND;
    localparam logic [4:0] PRESS_UP    = 5'd1 << BTN_UP;
    localparam logic [4:0] PRESS_LEFT  = 5'd1 << BTN_LEFT;
    localparam logic [4:0] PRESS_RIGHT = 5'd1 << BTN_RIGHT;
    localparam logic [4:0] PRESS_DOWN  = 5'd1 << BTN_DOWN;

    localparam int RANDOM_ITEMS = 650;
    // window of accepted samples in which neither side idles
    localparam int QUIET_FROM   = 300;
    localparam int QUIET_TO     = 420;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [4:0]          i_buttons = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic                o_send_valid;
    logic [FRAME_W-1:0]  o_frame;
    logic [15:0]         o_led_word;
    logic [7:0]          o_segment_word;

    dcc_command_panel_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_buttons      (i_buttons),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_send_valid   (o_send_valid),
        .o_frame        (o_frame),
        .o_led_word     (o_led_word),
        .o_segment_word (o_segment_word)
    );

    always #5 i_clk = ~i_clk;

    // button samples still to be offered, and panel results still owed
    logic [4:0] pending_buttons[$];
    t_result    expected_results[$];

    // model state of the panel
    t_panel_state       panel;
    logic [4:0]         held_buttons;
    logic [FRAME_W-1:0] stored_frame;

    int  accepted_count = 0;
    int  frames_sent = 0;
    int  extended_frames = 0;
    int  repeated_frames = 0;
    int  mismatches = 0;
    bit  button_taken = 1'b0;
    bit  draining = 1'b0;

    function automatic bit quiet_window();
        return accepted_count >= QUIET_FROM && accepted_count < QUIET_TO;
    endfunction

    // three-byte packet: preamble, address, command, xor check, end bit
    function automatic logic [FRAME_W-1:0] short_packet(logic [2:0] addr, logic [7:0] cmd);
        logic [7:0] chk;
        chk = {5'd0, addr} ^ cmd;
        return PREAMBLE3 | (FRAME_W'(addr) << 19) | (FRAME_W'(cmd) << 10)
             | (FRAME_W'(chk) << 1) | FRAME_W'(1);
    endfunction

    // frame for the current selection; selections past F20 repeat the stored frame
    function automatic logic [FRAME_W-1:0] dcc_frame_for_panel();
        logic [4:0] sel;
        logic       on;
        logic [7:0] data;
        logic [7:0] chk;
        sel = panel.function_select;
        on  = (panel.speed_or_on == 5'd1);
        if (sel == SEL_SPEED)
            return short_packet(panel.loco_address,
                                CMD_SPEED | {2'b00, panel.direction_bit, panel.speed_or_on});
        if (sel <= SEL_F4) begin
            data = (sel == SEL_F0) ? CMD_F0_BIT : (8'd1 << (sel - SEL_F1));
            return short_packet(panel.loco_address, CMD_FG1 | (on ? data : 8'd0));
        end
        if (sel <= SEL_F8)
            return short_packet(panel.loco_address,
                                CMD_FG2A | (on ? (8'd1 << (sel - SEL_F5)) : 8'd0));
        if (sel <= SEL_F12)
            return short_packet(panel.loco_address,
                                CMD_FG2B | (on ? (8'd1 << (sel - SEL_F9)) : 8'd0));
        if (sel <= SEL_F20) begin
            // f20 lands on 0x80 by the plain shift
            data = on ? (8'd1 << (sel - SEL_F13)) : 8'd0;
            chk  = {5'd0, panel.loco_address} ^ CMD_FEXP ^ data;
            return PREAMBLE4 | (FRAME_W'(panel.loco_address) << 28)
                 | (FRAME_W'(CMD_FEXP) << 19) | (FRAME_W'(data) << 10)
                 | (FRAME_W'(chk) << 1) | FRAME_W'(1);
        end
        return stored_frame;
    endfunction

    // one button sample through the panel; queues the result it owes
    task automatic step_panel(input logic [4:0] sample);
        logic [4:0] rising;
        logic [4:0] shown;
        t_result    res;
        rising = sample & ~held_buttons;
        res = '0;

        if (rising[BTN_SEND]) begin
            res.frame      = dcc_frame_for_panel();
            res.send_valid = 1'b1;
            stored_frame   = res.frame;
            frames_sent++;
            if (panel.function_select > SEL_F20)
                repeated_frames++;
            else if (panel.function_select >= SEL_F13)
                extended_frames++;
        end

        if (rising[BTN_UP]) begin
            case (panel.field_cursor)
                FLD_FUNCTION: begin
                    if (panel.function_select < MAX_FUNCTION) begin
                        panel.function_select = panel.function_select + 5'd1;
                        panel.direction_bit = 1'b0;
                        panel.speed_or_on = '0;
                    end
                end
                FLD_ADDRESS: begin
                    if (panel.loco_address < MAX_ADDRESS)
                        panel.loco_address = panel.loco_address + 3'd1;
                end
                FLD_DIRECTION: panel.direction_bit = 1'b1;
                default: begin
                    if (panel.function_select == SEL_SPEED) begin
                        if (panel.speed_or_on < MAX_SPEED)
                            panel.speed_or_on = panel.speed_or_on + 5'd1;
                    end else if (panel.speed_or_on == 5'd0) begin
                        panel.speed_or_on = 5'd1;
                    end
                end
            endcase
        end

        // the direction field only exists in speed mode
        if (rising[BTN_LEFT]) begin
            if (panel.field_cursor == FLD_SPEED)
                panel.field_cursor = (panel.function_select == SEL_SPEED) ?
                                     FLD_DIRECTION : FLD_ADDRESS;
            else if (panel.field_cursor != FLD_FUNCTION)
                panel.field_cursor = t_field'(panel.field_cursor - 2'd1);
        end

        if (rising[BTN_RIGHT]) begin
            if (panel.field_cursor == FLD_ADDRESS)
                panel.field_cursor = (panel.function_select == SEL_SPEED) ?
                                     FLD_DIRECTION : FLD_SPEED;
            else if (panel.field_cursor != FLD_SPEED)
                panel.field_cursor = t_field'(panel.field_cursor + 2'd1);
        end

        if (rising[BTN_DOWN]) begin
            case (panel.field_cursor)
                FLD_FUNCTION: begin
                    if (panel.function_select > SEL_SPEED) begin
                        panel.function_select = panel.function_select - 5'd1;
                        panel.direction_bit = 1'b0;
                        panel.speed_or_on = '0;
                    end
                end
                FLD_ADDRESS: begin
                    if (panel.loco_address > 3'd0)
                        panel.loco_address = panel.loco_address - 3'd1;
                end
                FLD_DIRECTION: panel.direction_bit = 1'b0;
                default: begin
                    if (panel.function_select == SEL_SPEED) begin
                        if (panel.speed_or_on > 5'd0)
                            panel.speed_or_on = panel.speed_or_on - 5'd1;
                    end else if (panel.speed_or_on == 5'd1) begin
                        panel.speed_or_on = 5'd0;
                    end
                end
            endcase
        end
        held_buttons = sample;

        case (panel.field_cursor)
            FLD_FUNCTION:  shown = panel.function_select;
            FLD_ADDRESS:   shown = {2'b00, panel.loco_address};
            FLD_DIRECTION: shown = {4'd0, panel.direction_bit};
            default:       shown = panel.speed_or_on;
        endcase
        res.led_word = {panel.function_select, panel.loco_address, panel.direction_bit,
                        1'b0, panel.speed_or_on, 1'b0};
        res.segment_word = {shown, panel.field_cursor, panel.function_select == SEL_SPEED};
        expected_results.push_back(res);
    endtask

    task automatic flag_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
    endtask

    // press then release, so the press gives one edge unless the button was already held
    task automatic tap(input logic [4:0] press);
        pending_buttons.push_back(press);
        pending_buttons.push_back(5'd0);
    endtask

    // stimulus: directed opening, then random button sequences
    initial begin : stimulus
        logic [4:0] opening[] = '{
            5'h01,                  // send straight after reset
            5'h08, 5'h18, 5'h00,    // cursor to address, lower it to the floor
            5'h08, 5'h0A, 5'h00,    // direction field, set it
            5'h08, 5'h00, 5'h08,    // speed field, then right at the end
            5'h0A, 5'h0B, 5'h00,    // speed up and send with it held
            5'h04, 5'h00, 5'h04, 5'h00, 5'h04, 5'h00, // walk back to function
            5'h1F, 5'h00,           // every edge at once, left at the start
            5'h08, 5'h0A, 5'h0B,    // skip over direction, switch on, send
            5'h00, 5'h04            // skip back over direction
        };
        int         target;
        int         pick;
        logic [4:0] btn;

        foreach (opening[n])
            pending_buttons.push_back(opening[n]);
        target = pending_buttons.size() + RANDOM_ITEMS;

        while (pending_buttons.size() < target) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                tap(5'd1 << $urandom_range(4));
            end else if (pick < 55) begin
                // run a field up or down, far enough to hit either limit
                btn = $urandom_range(1) ? PRESS_UP : PRESS_DOWN;
                repeat ($urandom_range(1, 32)) tap(btn);
            end else if (pick < 70) begin
                // move the cursor, adjust, send
                btn = $urandom_range(1) ? PRESS_LEFT : PRESS_RIGHT;
                repeat ($urandom_range(1, 3)) tap(btn);
                tap($urandom_range(1) ? PRESS_UP : PRESS_DOWN);
                tap(PRESS_SEND);
            end else if (pick < 82) begin
                tap(PRESS_SEND);
            end else begin
                // raw levels, overlapping presses and held buttons
                repeat ($urandom_range(1, 4)) pending_buttons.push_back(5'($urandom_range(31)));
            end
        end
    end

    // reset once, then wait for everything to drain
    initial begin : sequencer
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_buttons.size() == 0);
        draining = 1'b1;
        wait (expected_results.size() == 0);
        // catch any stray result after the last one owed
        repeat (8) @(posedge i_clk);
        $display("covered %0d button samples and %0d frames sent", accepted_count, frames_sent);
        $display("of those frames %0d were extended-function and %0d repeats",
                 extended_frames, repeated_frames);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // input side: take the transaction into the model at the rising edge
    always @(posedge i_clk) begin
        button_taken = 1'b0;
        if (!i_rst_n) begin
            panel.function_select = SEL_SPEED;
            panel.loco_address    = 3'd1;
            panel.direction_bit   = 1'b0;
            panel.speed_or_on     = '0;
            panel.field_cursor    = FLD_FUNCTION;
            held_buttons          = '0;
            stored_frame          = '0;
        end else if (i_valid && !o_stall) begin
            button_taken = 1'b1;
            void'(pending_buttons.pop_front());
            accepted_count++;
            step_panel(i_buttons);
        end
    end

    // input driver: hold while stalled, otherwise offer the next sample or idle
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_valid && !button_taken)) begin
            if (pending_buttons.size() != 0
                    && (quiet_window() || $urandom_range(99) >= 28)) begin
                i_valid   <= 1'b1;
                i_buttons <= pending_buttons[0];
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // output side: stall at random, none in the quiet window or while draining
    always @(negedge i_clk) begin
        if (i_rst_n)
            i_stall <= !draining && !quiet_window() && ($urandom_range(99) < 28);
    end

    // result checker
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t ns: result with none owed, frame 0x%0h led 0x%0h seg 0x%0h",
                         $time, o_frame, o_led_word, o_segment_word);
            end else begin
                want = expected_results.pop_front();
                if (o_send_valid !== want.send_valid)
                    flag_mismatch("send_valid", 64'(want.send_valid), 64'(o_send_valid));
                if (o_frame !== want.frame)
                    flag_mismatch("frame", 64'(want.frame), 64'(o_frame));
                if (o_led_word !== want.led_word)
                    flag_mismatch("led_word", 64'(want.led_word), 64'(o_led_word));
                if (o_segment_word !== want.segment_word)
                    flag_mismatch("segment_word", 64'(want.segment_word), 64'(o_segment_word));
            end
        end
    end

endmodule

// ===== sim.f =====
src/dcc_cp_pkg.sv
src/dcc_cp_frame.sv
src/dcc_cp_ctrl.sv
src/dcc_command_panel_unit.sv
bench/testbench.sv
